>>> src/turing_machine_stepper_top_assert.svh
// Assertion macros used by the Turing machine stepper RTL.
`ifndef TURING_MACHINE_STEPPER_TOP_ASSERT_SVH
`define TURING_MACHINE_STEPPER_TOP_ASSERT_SVH

// The expression must hold at every clock edge outside reset.
`define TMS_CHECK(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define TMS_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/tms_pkg.sv
// Types and constants of the Turing machine stepper.
`timescale 1ns / 1ps

package tms_pkg;

   localparam int TAPE_CELLS_DEFAULT = 4096;
   localparam int SYMBOL_COUNT       = 2;
   localparam int STATE_COUNT        = 8;

   localparam int KIND_W  = 2;
   localparam int SYM_W   = 1;
   localparam int STATE_W = 3;
   localparam int POS_W   = 12;
   localparam int CAUSE_W = 2;
   localparam int COUNT_W = 32;

   localparam logic [COUNT_W-1:0] STEP_LIMIT_RESET = 32'd1000000;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD    = 2'd0,
      KIND_STEP    = 2'd1,
      KIND_RESTART = 2'd2,
      KIND_CLEAR   = 2'd3
   } kind_type;

   typedef enum logic [CAUSE_W-1:0] {
      HALT_NONE    = 2'd0,
      HALT_DONE    = 2'd1,
      HALT_BOUNDS  = 2'd2,
      HALT_LIMIT   = 2'd3
   } halt_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   // One transition rule: symbol to write, move (0 left, 1 right), next state.
   typedef struct packed {
      logic [SYM_W-1:0]   write;
      logic               move;
      logic [STATE_W-1:0] next;
   } rule_type;

   localparam int RULE_W = $bits(rule_type);

endpackage

>>> src/turing_machine_stepper_top.sv
// Top level of the Turing machine stepper: tape and rule memories with step control.
//
//   channel  direction  handshake                      contents
//   req_     in         req_valid / req_ready          kind and rule entry fields
//   rsp_     out        rsp_valid / rsp_ready          machine status after the request
//   csr_     in         csr_write_enable, no wait      step limit
//
// A request is accepted in the idle state, whose cycle reads the tape cell under the
// head and both rule memories at the current state; the execute state applies it.
// A request is accepted while the previous response still waits; it completes once
// that response is taken. Synchronous reset clears all control state.
// Tape cells outside the visited span read as zero, so reset and restart need no
// clearing pass; the rule table has one valid bit per entry.
`timescale 1ns / 1ps
`include "turing_machine_stepper_top_assert.svh"

module turing_machine_stepper_top #(
   parameter int TAPE_CELLS = tms_pkg::TAPE_CELLS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [tms_pkg::KIND_W-1:0]   req_kind,
   input  logic [tms_pkg::SYM_W-1:0]    req_entry_symbol,
   input  logic [tms_pkg::STATE_W-1:0]  req_entry_state,
   input  logic [tms_pkg::SYM_W-1:0]    req_entry_write,
   input  logic                         req_entry_move,
   input  logic [tms_pkg::STATE_W-1:0]  req_entry_next,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tms_pkg::POS_W-1:0]    rsp_head_position,
   output logic [tms_pkg::STATE_W-1:0]  rsp_machine_state,
   output logic                         rsp_is_halted,
   output logic [tms_pkg::CAUSE_W-1:0]  rsp_halt_reason,
   output logic [tms_pkg::POS_W-1:0]    rsp_visited_low,
   output logic [tms_pkg::POS_W-1:0]    rsp_visited_high,
   output logic [tms_pkg::COUNT_W-1:0]  rsp_steps_done,
   input  logic                         csr_write_enable,
   input  logic [tms_pkg::COUNT_W-1:0]  csr_write_data
);

   import tms_pkg::*;

   localparam int HeadW = $clog2(TAPE_CELLS);
   localparam logic [HeadW-1:0] HeadMid  = HeadW'(TAPE_CELLS / 2);
   localparam logic [HeadW-1:0] HeadLast = HeadW'(TAPE_CELLS - 1);

   fsm_type fsm_ff, fsm_in;
   logic    req_accept;
   logic    exec_go;

   kind_type           kind_ff, kind_in;
   logic [SYM_W-1:0]   ent_sym_ff, ent_sym_in;
   logic [STATE_W-1:0] ent_state_ff, ent_state_in;
   rule_type           ent_rule_ff, ent_rule_in;

   logic [HeadW-1:0]   head_ff, head_in;
   logic [HeadW-1:0]   low_ff, low_in;
   logic [HeadW-1:0]   high_ff, high_in;
   logic [STATE_W-1:0] state_ff, state_in;
   logic               halted_ff, halted_in;
   halt_type           cause_ff, cause_in;
   logic [COUNT_W-1:0] steps_ff, steps_in;
   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic               written_ff, written_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATE_COUNT-1:0] rule_valid_ff [SYMBOL_COUNT];
   logic [STATE_COUNT-1:0] rule_valid_in [SYMBOL_COUNT];

   logic [SYM_W-1:0]   tape_rd;
   logic [SYM_W-1:0]   tape_bit;
   logic               tape_we;
   rule_type           rule_rd [SYMBOL_COUNT];
   rule_type           rule_sel;
   logic [COUNT_W-1:0] steps_inc;

   // ---------------------------------------------------------------- control
   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               fsm_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (exec_go) begin
               fsm_in = FSM_IDLE;
            end
         end
         default: fsm_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      exec_go   = 1'b0;
      case (fsm_ff)
         FSM_IDLE: req_ready = 1'b1;
         FSM_EXEC: exec_go   = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            exec_go   = 1'b0;
         end
      endcase
   end

   assign req_accept = req_valid && req_ready;

   assign kind_in      = req_accept ? kind_type'(req_kind) : kind_ff;
   assign ent_sym_in   = req_accept ? req_entry_symbol : ent_sym_ff;
   assign ent_state_in = req_accept ? req_entry_state : ent_state_ff;
   assign ent_rule_in  = req_accept ? rule_type'({req_entry_write, req_entry_move,
                                                  req_entry_next}) : ent_rule_ff;

   assign rsp_valid_in = exec_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign limit_in     = csr_write_enable ? csr_write_data : limit_ff;

   // ---------------------------------------------------------------- memories
   tms_ram #(
      .WIDTH (SYM_W),
      .DEPTH (TAPE_CELLS)
   ) u_tape (
      .clock   (clock),
      .wr_en   (tape_we),
      .wr_addr (head_ff),
      .wr_data (rule_sel.write),
      .rd_en   (req_accept),
      .rd_addr (head_ff),
      .rd_data (tape_rd)
   );

   for (genvar g = 0; g < SYMBOL_COUNT; g++) begin : g_rule
      logic [RULE_W-1:0] rd_word;

      tms_ram #(
         .WIDTH (RULE_W),
         .DEPTH (STATE_COUNT)
      ) u_rule (
         .clock   (clock),
         .wr_en   (exec_go && kind_ff == KIND_LOAD && ent_sym_ff == SYM_W'(g)),
         .wr_addr (ent_state_ff),
         .wr_data (ent_rule_ff),
         .rd_en   (req_accept),
         .rd_addr (state_ff),
         .rd_data (rd_word)
      );

      assign rule_rd[g] = rule_type'(rd_word);
   end

   // Only cells inside the span written since restart hold live data.
   assign tape_bit = (written_ff && head_ff >= low_ff && head_ff <= high_ff) ? tape_rd : '0;
   assign rule_sel = rule_valid_ff[tape_bit][state_ff] ? rule_rd[tape_bit] : '0;
   assign steps_inc = steps_ff + COUNT_W'(1);

   // ---------------------------------------------------------------- datapath
   always_comb begin
      head_in    = head_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      state_in   = state_ff;
      halted_in  = halted_ff;
      cause_in   = cause_ff;
      steps_in   = steps_ff;
      written_in = written_ff;
      tape_we    = 1'b0;
      rule_valid_in = rule_valid_ff;

      if (exec_go) begin
         case (kind_ff)
            KIND_LOAD: begin
               rule_valid_in[ent_sym_ff][ent_state_ff] = 1'b1;
            end
            KIND_STEP: begin
               if (halted_ff) begin
                  halted_in = halted_ff;
               end else if (steps_ff >= limit_ff) begin
                  state_in  = '0;
                  halted_in = 1'b1;
                  cause_in  = HALT_LIMIT;
               end else if (state_ff == '0) begin
                  halted_in = 1'b1;
                  cause_in  = HALT_DONE;
               end else begin
                  tape_we    = 1'b1;
                  written_in = 1'b1;
                  steps_in   = steps_inc;
                  if (head_ff < low_ff) begin
                     low_in = head_ff;
                  end
                  if (head_ff > high_ff) begin
                     high_in = head_ff;
                  end
                  // Leaving either end keeps the head on the edge cell.
                  if ((!rule_sel.move && head_ff == '0) ||
                      (rule_sel.move && head_ff >= HeadLast)) begin
                     state_in  = '0;
                     halted_in = 1'b1;
                     cause_in  = HALT_BOUNDS;
                  end else begin
                     head_in  = rule_sel.move ? head_ff + HeadW'(1) : head_ff - HeadW'(1);
                     state_in = rule_sel.next;
                     if (rule_sel.next == '0) begin
                        halted_in = 1'b1;
                        cause_in  = HALT_DONE;
                     end else if (steps_inc >= limit_ff) begin
                        state_in  = '0;
                        halted_in = 1'b1;
                        cause_in  = HALT_LIMIT;
                     end
                  end
               end
            end
            KIND_RESTART, KIND_CLEAR: begin
               head_in    = HeadMid;
               low_in     = HeadMid;
               high_in    = HeadMid;
               state_in   = STATE_W'(1);
               halted_in  = 1'b0;
               cause_in   = HALT_NONE;
               steps_in   = '0;
               written_in = 1'b0;
               if (kind_ff == KIND_CLEAR) begin
                  for (int s = 0; s < SYMBOL_COUNT; s++) begin
                     rule_valid_in[s] = '0;
                  end
               end
            end
            default: begin
               tape_we = 1'b0;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= FSM_IDLE;
         head_ff      <= HeadMid;
         low_ff       <= HeadMid;
         high_ff      <= HeadMid;
         state_ff     <= STATE_W'(1);
         halted_ff    <= 1'b0;
         cause_ff     <= HALT_NONE;
         steps_ff     <= '0;
         limit_ff     <= STEP_LIMIT_RESET;
         written_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SYMBOL_COUNT; s++) begin
            rule_valid_ff[s] <= '0;
         end
      end else begin
         fsm_ff        <= fsm_in;
         head_ff       <= head_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
         state_ff      <= state_in;
         halted_ff     <= halted_in;
         cause_ff      <= cause_in;
         steps_ff      <= steps_in;
         limit_ff      <= limit_in;
         written_ff    <= written_in;
         rsp_valid_ff  <= rsp_valid_in;
         rule_valid_ff <= rule_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      ent_sym_ff   <= ent_sym_in;
      ent_state_ff <= ent_state_in;
      ent_rule_ff  <= ent_rule_in;
   end

   // The status registers stand as the response register until the next request runs.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_head_position = POS_W'(head_ff);
   assign rsp_machine_state = state_ff;
   assign rsp_is_halted     = halted_ff;
   assign rsp_halt_reason   = cause_ff;
   assign rsp_visited_low   = POS_W'(low_ff);
   assign rsp_visited_high  = POS_W'(high_ff);
   assign rsp_steps_done    = steps_ff;

   // ---------------------------------------------------------------- assertions
   `TMS_CHECK(a_halt_consistent, halted_ff == (cause_ff != HALT_NONE), "halt flag and cause disagree")
   `TMS_CHECK(a_halt_state_zero, !halted_ff || cause_ff == HALT_DONE || state_ff == '0, "halted machine keeps a state")
   `TMS_CHECK(a_span_ordered, low_ff <= high_ff && high_ff <= HeadLast, "visited span is malformed")
   `TMS_CHECK_NEXT(a_accept_runs, req_accept, fsm_ff == FSM_EXEC && !req_ready, "accepted request does not execute")
   `TMS_CHECK_NEXT(a_stall_holds, fsm_ff == FSM_EXEC && !exec_go, $stable(head_ff) && $stable(steps_ff) && rsp_valid_ff, "status changed while the response waits")

endmodule

>>> src/tms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module tms_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/tms_status_checker.sv
// Status checker for the Turing machine stepper: tracks the machine and compares every response.
`timescale 1ns / 1ps

module tms_status_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [tms_pkg::KIND_W-1:0]    req_kind,
   input  logic [tms_pkg::SYM_W-1:0]     req_entry_symbol,
   input  logic [tms_pkg::STATE_W-1:0]   req_entry_state,
   input  logic [tms_pkg::SYM_W-1:0]     req_entry_write,
   input  logic                          req_entry_move,
   input  logic [tms_pkg::STATE_W-1:0]   req_entry_next,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [tms_pkg::POS_W-1:0]     rsp_head_position,
   input  logic [tms_pkg::STATE_W-1:0]   rsp_machine_state,
   input  logic                          rsp_is_halted,
   input  logic [tms_pkg::CAUSE_W-1:0]   rsp_halt_reason,
   input  logic [tms_pkg::POS_W-1:0]     rsp_visited_low,
   input  logic [tms_pkg::POS_W-1:0]     rsp_visited_high,
   input  logic [tms_pkg::COUNT_W-1:0]   rsp_steps_done,
   input  logic                          csr_write_enable,
   input  logic [tms_pkg::COUNT_W-1:0]   csr_write_data,
   output int                            open_count,
   output int                            mismatch_count,
   output int                            checked_count
);

   import tms_pkg::*;

   localparam int CELLS = TAPE_CELLS_DEFAULT;

   typedef struct packed {
      logic [POS_W-1:0]   head_cell;
      logic [STATE_W-1:0] machine_state;
      logic               halted;
      logic [CAUSE_W-1:0] reason;
      logic [POS_W-1:0]   low_cell;
      logic [POS_W-1:0]   high_cell;
      logic [COUNT_W-1:0] steps;
   } status_type;

   logic               tape_bits [CELLS];
   rule_type           rules [SYMBOL_COUNT*STATE_COUNT];
   logic [POS_W-1:0]   head_cell;
   logic [POS_W-1:0]   low_cell;
   logic [POS_W-1:0]   high_cell;
   logic [STATE_W-1:0] state_now;
   logic               halted;
   halt_type           cause;
   logic [COUNT_W-1:0] step_total;
   logic [COUNT_W-1:0] step_cap;
   status_type         expected_status [$];
   status_type         got;
   status_type         want;
   int                 mismatches = 0;
   int                 checked = 0;

   function void clear_run();
      foreach (tape_bits[i]) tape_bits[i] = 1'b0;
      head_cell  = POS_W'(CELLS / 2);
      low_cell   = head_cell;
      high_cell  = head_cell;
      state_now  = STATE_W'(1);
      halted     = 1'b0;
      cause      = HALT_NONE;
      step_total = '0;
   endfunction

   function void halt_machine(input halt_type why);
      state_now = '0;
      halted    = 1'b1;
      cause     = why;
   endfunction

   function void take_step();
      int       idx;
      rule_type r;
      if (halted) return;
      // A step that finds the budget spent halts without touching the tape.
      if (step_total >= step_cap) begin
         halt_machine(HALT_LIMIT);
         return;
      end
      if (state_now == '0) begin
         halt_machine(HALT_DONE);
         return;
      end
      idx = int'(tape_bits[head_cell]) * STATE_COUNT + int'(state_now);
      r = rules[idx];
      tape_bits[head_cell] = r.write;
      if (head_cell < low_cell) low_cell = head_cell;
      if (head_cell > high_cell) high_cell = head_cell;
      step_total++;
      // Leaving the tape keeps the head on the edge cell; the write still counts.
      if (r.move == 1'b0) begin
         if (head_cell == '0) begin
            halt_machine(HALT_BOUNDS);
            return;
         end
         head_cell--;
      end else begin
         if (int'(head_cell) >= CELLS - 1) begin
            halt_machine(HALT_BOUNDS);
            return;
         end
         head_cell++;
      end
      state_now = r.next;
      if (state_now == '0) begin
         halt_machine(HALT_DONE);
         return;
      end
      if (step_total >= step_cap) halt_machine(HALT_LIMIT);
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rules = '{default: '0};
         clear_run();
         step_cap = STEP_LIMIT_RESET;
         expected_status.delete();
      end else begin
         if (csr_write_enable) step_cap = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_head_position, rsp_machine_state, rsp_is_halted, rsp_halt_reason,
                    rsp_visited_low, rsp_visited_high, rsp_steps_done};
            checked++;
            if (expected_status.size() == 0) begin
               report_mismatch($sformatf("response with none outstanding, head %0d",
                                         got.head_cell));
            end else begin
               want = expected_status.pop_front();
               if (got.head_cell !== want.head_cell)
                  report_mismatch($sformatf("head_position %0d, expected %0d",
                                            got.head_cell, want.head_cell));
               if (got.machine_state !== want.machine_state)
                  report_mismatch($sformatf("machine_state %0d, expected %0d",
                                            got.machine_state, want.machine_state));
               if (got.halted !== want.halted)
                  report_mismatch($sformatf("is_halted %0d, expected %0d",
                                            got.halted, want.halted));
               if (got.reason !== want.reason)
                  report_mismatch($sformatf("halt_reason %0d, expected %0d",
                                            got.reason, want.reason));
               if (got.low_cell !== want.low_cell)
                  report_mismatch($sformatf("visited_low %0d, expected %0d",
                                            got.low_cell, want.low_cell));
               if (got.high_cell !== want.high_cell)
                  report_mismatch($sformatf("visited_high %0d, expected %0d",
                                            got.high_cell, want.high_cell));
               if (got.steps !== want.steps)
                  report_mismatch($sformatf("steps_done %0d, expected %0d",
                                            got.steps, want.steps));
            end
         end
         if (req_valid && req_ready) begin
            case (req_kind)
               KIND_LOAD: begin
                  rules[int'(req_entry_symbol) * STATE_COUNT + int'(req_entry_state)] =
                     '{write: req_entry_write, move: req_entry_move, next: req_entry_next};
               end
               KIND_STEP: take_step();
               KIND_RESTART: clear_run();
               default: begin
                  rules = '{default: '0};
                  clear_run();
               end
            endcase
            expected_status.push_back(status_type'{head_cell, state_now, halted, cause,
                                                   low_cell, high_cell, step_total});
         end
      end
      open_count     <= expected_status.size();
      mismatch_count <= mismatches;
      checked_count  <= checked;
   end

endmodule

>>> tb/testbench.sv
// Top of the Turing machine stepper testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import tms_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [KIND_W-1:0]    req_kind = '0;
   logic [SYM_W-1:0]     req_entry_symbol = '0;
   logic [STATE_W-1:0]   req_entry_state = '0;
   logic [SYM_W-1:0]     req_entry_write = '0;
   logic                 req_entry_move = 1'b0;
   logic [STATE_W-1:0]   req_entry_next = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [POS_W-1:0]     rsp_head_position;
   logic [STATE_W-1:0]   rsp_machine_state;
   logic                 rsp_is_halted;
   logic [CAUSE_W-1:0]   rsp_halt_reason;
   logic [POS_W-1:0]     rsp_visited_low;
   logic [POS_W-1:0]     rsp_visited_high;
   logic [COUNT_W-1:0]   rsp_steps_done;
   logic                 csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]   csr_write_data = '0;
   int                   open_count;
   int                   mismatch_count;
   int                   checked_count;

   int burst_left = 0;
   int sent_total = 0;
   int sent_by_kind [4] = '{default: 0};
   int limit_settings = 0;
   int stall_mode = 0;
   int mode_left = 0;

   turing_machine_stepper_top dut (.*);
   tms_status_checker status_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Response side: long stretches of always-ready, coin flips, or mostly stalled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Presents one request; returns at the edge that accepts it, or after the pause
   // that ends a burst. In a burst valid stays high, so requests follow with no gap.
   task automatic send_request(input kind_type kind, input logic sym,
                               input logic [STATE_W-1:0] st, input logic wr,
                               input logic mv, input logic [STATE_W-1:0] nx);
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_entry_symbol <= sym;
      req_entry_state  <= st;
      req_entry_write  <= wr;
      req_entry_move   <= mv;
      req_entry_next   <= nx;
      do @(posedge clock); while (!req_ready);
      sent_total++;
      sent_by_kind[kind]++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(0, 8);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // The rule fields are random; they matter only when the kind is a load.
   task automatic send_command(input kind_type kind);
      send_request(kind, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   3'($urandom_range(0, 7)));
   endtask

   // Most random rules continue the run so that programs get past a few steps.
   task automatic load_random_rule(input logic sym, input logic [STATE_W-1:0] st);
      send_request(KIND_LOAD, sym, st, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   ($urandom_range(0, 9) == 0) ? 3'd0 : 3'($urandom_range(1, 7)));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limit(input logic [COUNT_W-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      limit_settings++;
   endtask

   initial begin
      #5_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, halted steps, extreme rule fields, both restarts.
      set_limit(32'hFFFF_FFFF);
      send_command(KIND_STEP);
      send_command(KIND_STEP);
      send_request(KIND_LOAD, 1'b0, 3'd0, 1'b1, 1'b1, 3'd7);
      send_request(KIND_LOAD, 1'b0, 3'd1, 1'b1, 1'b1, 3'd2);
      send_request(KIND_LOAD, 1'b1, 3'd1, 1'b0, 1'b0, 3'd7);
      send_request(KIND_LOAD, 1'b0, 3'd2, 1'b1, 1'b0, 3'd1);
      send_request(KIND_LOAD, 1'b1, 3'd2, 1'b1, 1'b1, 3'd0);
      send_request(KIND_LOAD, 1'b0, 3'd7, 1'b0, 1'b1, 3'd1);
      send_request(KIND_LOAD, 1'b1, 3'd7, 1'b1, 1'b0, 3'd1);
      send_command(KIND_RESTART);
      repeat (6) send_command(KIND_STEP);
      send_command(KIND_CLEAR);
      send_command(KIND_STEP);

      // A zero budget halts the very first step by limit.
      set_limit(32'd0);
      send_command(KIND_RESTART);
      send_command(KIND_STEP);

      // Budget of one: a continuing step halts by limit, a halting step stays natural.
      set_limit(32'd1);
      send_request(KIND_LOAD, 1'b0, 3'd1, 1'b1, 1'b1, 3'd3);
      send_command(KIND_RESTART);
      send_command(KIND_STEP);
      send_request(KIND_LOAD, 1'b0, 3'd1, 1'b0, 1'b0, 3'd0);
      send_command(KIND_RESTART);
      send_command(KIND_STEP);

      // Random programs: load rules, restart, run, with stray requests mixed in.
      while (sent_total < 950) begin
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 7))
               0: set_limit(32'd0);
               1: set_limit(32'd1);
               2, 3: set_limit(32'($urandom_range(2, 40)));
               4: set_limit(32'($urandom_range(41, 300)));
               5: set_limit(STEP_LIMIT_RESET);
               6: set_limit(32'hFFFF_FFFF);
               default: set_limit($urandom());
            endcase
         end
         if ($urandom_range(0, 3) == 0) send_command(KIND_CLEAR);
         if ($urandom_range(0, 1) == 0) begin
            for (int st = 0; st < STATE_COUNT; st++) begin
               load_random_rule(1'b0, 3'(st));
               load_random_rule(1'b1, 3'(st));
            end
         end else begin
            repeat ($urandom_range(1, 6))
               load_random_rule(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
         end
         send_command(KIND_RESTART);
         repeat ($urandom_range(4, 60)) begin
            if ($urandom_range(0, 9) == 0) send_command(kind_type'($urandom_range(0, 3)));
            else send_command(KIND_STEP);
         end
         if ($urandom_range(0, 4) == 0) wait_idle();
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("Ran %0d rule loads, %0d steps and %0d restarts (%0d clearing the table)",
               sent_by_kind[KIND_LOAD], sent_by_kind[KIND_STEP],
               sent_by_kind[KIND_RESTART] + sent_by_kind[KIND_CLEAR], sent_by_kind[KIND_CLEAR]);
      $display("under %0d step-limit settings; %0d responses compared.",
               limit_settings, checked_count);
      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
